[rtl/sfp_pkg.sv]
// Package for the SAM record field parser: result type, character codes,
// field indexes and the CIGAR operation decode. No dependencies.
package sfp_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field positions within a line (zero based).
  localparam logic [3:0] FLD_FLAG  = 4'd1;
  localparam logic [3:0] FLD_POS   = 4'd3;
  localparam logic [3:0] FLD_MAPQ  = 4'd4;
  localparam logic [3:0] FLD_CIGAR = 4'd5;
  localparam logic [3:0] FLD_MPOS  = 4'd7;
  localparam logic [3:0] FLD_TLEN  = 4'd8;
  localparam logic [3:0] FLD_SEQ   = 4'd9;
  localparam logic [3:0] FLD_QUAL  = 4'd10;
  localparam logic [3:0] FLD_MAX   = 4'd15;
  // A field index at or above this means optional tags are present.
  localparam logic [3:0] FLD_OPT   = 4'd11;

  // Saturation limits.
  localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] FLAG_MAX  = 32'h0000_FFFF;
  localparam logic [31:0] MAPQ_MAX  = 32'h0000_00FF;
  localparam logic [27:0] CIGAR_CAP = 28'hFFF_FFFF;

  // Result kinds.
  localparam logic KIND_CIGAR  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // CIGAR operation codes.
  localparam logic [3:0] OP_M   = 4'd0;
  localparam logic [3:0] OP_I   = 4'd1;
  localparam logic [3:0] OP_D   = 4'd2;
  localparam logic [3:0] OP_N   = 4'd3;
  localparam logic [3:0] OP_S   = 4'd4;
  localparam logic [3:0] OP_H   = 4'd5;
  localparam logic [3:0] OP_P   = 4'd6;
  localparam logic [3:0] OP_EQ  = 4'd7;
  localparam logic [3:0] OP_X   = 4'd8;
  localparam logic [3:0] OP_UNK = 4'd9;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [3:0]  cigar_type;
    logic [27:0] cigar_length;
    logic [15:0] flag_bits;
    logic [30:0] position;
    logic [7:0]  map_quality;
    logic [30:0] mate_position;
    logic [31:0] template_length;
    logic        has_sequence;
    logic        has_quality;
    logic        has_optional;
    logic        well_formed;
  } res_t;

  // Map an operation character to its code.
  function automatic logic [3:0] op_code(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      8'h4D:   c = OP_M;
      8'h49:   c = OP_I;
      8'h44:   c = OP_D;
      8'h4E:   c = OP_N;
      8'h53:   c = OP_S;
      8'h48:   c = OP_H;
      8'h50:   c = OP_P;
      8'h3D:   c = OP_EQ;
      8'h58:   c = OP_X;
      default: c = OP_UNK;
    endcase
    return c;
  endfunction

endpackage

[rtl/sfp_core.sv]
// Per-line parsing state and the combinational update for one text byte.
// Depends on sfp_pkg for codes, limits and the result type.
module sfp_core
  import sfp_pkg::*;
#(
  parameter int MIN_FIELDS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output res_t       res
);

  logic [3:0]  field_index_r,  field_index_nxt;
  logic        line_start_r,   line_start_nxt;
  logic        skip_hdr_r,     skip_hdr_nxt;
  logic [31:0] num_acc_r,      num_acc_nxt;
  logic        num_neg_r,      num_neg_nxt;
  logic        num_stop_r,     num_stop_nxt;
  logic [27:0] cig_acc_r,      cig_acc_nxt;
  logic [15:0] flags_r,        flags_nxt;
  logic [30:0] pos_r,          pos_nxt;
  logic [7:0]  mapq_r,         mapq_nxt;
  logic [30:0] mpos_r,         mpos_nxt;
  logic [31:0] tlen_r,         tlen_nxt;
  logic [1:0]  char_cnt_r,     char_cnt_nxt;
  logic        is_star_r,      is_star_nxt;
  logic        seq_r,          seq_nxt;
  logic        qual_r,         qual_nxt;

  // Values of the held fields once the current field is closed.
  logic [15:0] ef_flags;
  logic [30:0] ef_pos;
  logic [7:0]  ef_mapq;
  logic [30:0] ef_mpos;
  logic [31:0] ef_tlen;
  logic        ef_seq;
  logic        ef_qual;

  logic        present;
  logic [31:0] uclamp_pos;
  logic [31:0] uclamp_flag;
  logic [31:0] uclamp_mapq;
  logic [31:0] neg_mag;
  logic [31:0] sclamp;
  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] num_x10;
  logic [31:0] cig_x10;
  logic        skip_now;
  logic [4:0]  fields_seen;

  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign digit    = byte_in[3:0];
  assign present  = !((char_cnt_r == 2'd1) && is_star_r);

  // Clamp the accumulated magnitude into each field's range.
  assign uclamp_pos  = num_neg_r ? 32'd0 : ((num_acc_r > POS_MAX)  ? POS_MAX  : num_acc_r);
  assign uclamp_flag = num_neg_r ? 32'd0 : ((num_acc_r > FLAG_MAX) ? FLAG_MAX : num_acc_r);
  assign uclamp_mapq = num_neg_r ? 32'd0 : ((num_acc_r > MAPQ_MAX) ? MAPQ_MAX : num_acc_r);
  assign neg_mag     = (num_acc_r > MAG_CAP) ? MAG_CAP : num_acc_r;
  assign sclamp      = num_neg_r ? (32'd0 - neg_mag) : uclamp_pos;

  // Decimal accumulate: times ten by shift and add.
  assign num_x10 = {1'b0, num_acc_r, 3'b000} + {3'b000, num_acc_r, 1'b0}
                 + {32'd0, digit};
  assign cig_x10 = {1'b0, cig_acc_r, 3'b000} + {3'b000, cig_acc_r, 1'b0}
                 + {28'd0, digit};

  assign fields_seen = {1'b0, field_index_r} + 5'd1;

  // Close the current field into the held values.
  always_comb begin
    ef_flags = flags_r;
    ef_pos   = pos_r;
    ef_mapq  = mapq_r;
    ef_mpos  = mpos_r;
    ef_tlen  = tlen_r;
    ef_seq   = seq_r;
    ef_qual  = qual_r;
    case (field_index_r)
      FLD_FLAG: ef_flags = uclamp_flag[15:0];
      FLD_POS:  ef_pos   = uclamp_pos[30:0];
      FLD_MAPQ: ef_mapq  = uclamp_mapq[7:0];
      FLD_MPOS: ef_mpos  = uclamp_pos[30:0];
      FLD_TLEN: ef_tlen  = sclamp;
      FLD_SEQ:  ef_seq   = present;
      FLD_QUAL: ef_qual  = present;
      default:  ef_seq   = seq_r;
    endcase
  end

  assign skip_now = skip_hdr_r || (line_start_r && (byte_in == CH_AT));

  // Next state and result for one byte.
  always_comb begin
    field_index_nxt = field_index_r;
    line_start_nxt  = line_start_r;
    skip_hdr_nxt    = skip_hdr_r;
    num_acc_nxt     = num_acc_r;
    num_neg_nxt     = num_neg_r;
    num_stop_nxt    = num_stop_r;
    cig_acc_nxt     = cig_acc_r;
    flags_nxt       = flags_r;
    pos_nxt         = pos_r;
    mapq_nxt        = mapq_r;
    mpos_nxt        = mpos_r;
    tlen_nxt        = tlen_r;
    char_cnt_nxt    = char_cnt_r;
    is_star_nxt     = is_star_r;
    seq_nxt         = seq_r;
    qual_nxt        = qual_r;
    res_valid       = 1'b0;
    res             = '0;

    if (byte_in == CH_NL) begin
      // End of line: report unless it was a header, then clear the line.
      if (!skip_hdr_r) begin
        res_valid           = 1'b1;
        res.kind            = KIND_RECORD;
        res.flag_bits       = ef_flags;
        res.position        = ef_pos;
        res.map_quality     = ef_mapq;
        res.mate_position   = ef_mpos;
        res.template_length = ef_tlen;
        res.has_sequence    = ef_seq;
        res.has_quality     = ef_qual;
        res.has_optional    = (field_index_r >= FLD_OPT);
        res.well_formed     = (fields_seen >= 5'(MIN_FIELDS));
      end
      skip_hdr_nxt    = 1'b0;
      line_start_nxt  = 1'b1;
      field_index_nxt = '0;
      num_acc_nxt     = '0;
      num_neg_nxt     = 1'b0;
      num_stop_nxt    = 1'b0;
      cig_acc_nxt     = '0;
      char_cnt_nxt    = '0;
      is_star_nxt     = 1'b0;
      flags_nxt       = '0;
      pos_nxt         = '0;
      mapq_nxt        = '0;
      mpos_nxt        = '0;
      tlen_nxt        = '0;
      seq_nxt         = 1'b0;
      qual_nxt        = 1'b0;
    end else begin
      line_start_nxt = 1'b0;
      if (skip_now) begin
        skip_hdr_nxt = 1'b1;
      end else if (byte_in == CH_TAB) begin
        // Field separator: store the field and start the next one.
        flags_nxt    = ef_flags;
        pos_nxt      = ef_pos;
        mapq_nxt     = ef_mapq;
        mpos_nxt     = ef_mpos;
        tlen_nxt     = ef_tlen;
        seq_nxt      = ef_seq;
        qual_nxt     = ef_qual;
        num_acc_nxt  = '0;
        num_neg_nxt  = 1'b0;
        num_stop_nxt = 1'b0;
        cig_acc_nxt  = '0;
        char_cnt_nxt = '0;
        is_star_nxt  = 1'b0;
        if (field_index_r != FLD_MAX) begin
          field_index_nxt = field_index_r + 4'd1;
        end
      end else begin
        case (field_index_r)
          FLD_FLAG, FLD_POS, FLD_MAPQ, FLD_MPOS, FLD_TLEN: begin
            // Numeric field: optional sign first, then digits until a stop.
            if (!num_stop_r) begin
              if ((char_cnt_r == 2'd0) && ((byte_in == CH_PLUS) || (byte_in == CH_MINUS))) begin
                num_neg_nxt = (byte_in == CH_MINUS);
              end else if (is_digit) begin
                num_acc_nxt = (num_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : num_x10[31:0];
              end else begin
                num_stop_nxt = 1'b1;
              end
            end
          end
          FLD_CIGAR: begin
            // CIGAR: digits build a length, other characters but a star emit an operation.
            if (is_digit) begin
              cig_acc_nxt = (cig_x10 > {4'd0, CIGAR_CAP}) ? CIGAR_CAP : cig_x10[27:0];
            end else if (byte_in != CH_STAR) begin
              res_valid        = 1'b1;
              res.kind         = KIND_CIGAR;
              res.cigar_type   = op_code(byte_in);
              res.cigar_length = cig_acc_r;
              cig_acc_nxt      = '0;
            end
          end
          default: begin
            num_stop_nxt = num_stop_r;
          end
        endcase
        if (char_cnt_r == 2'd0) begin
          is_star_nxt = (byte_in == CH_STAR);
        end
        if (char_cnt_r != 2'd2) begin
          char_cnt_nxt = char_cnt_r + 2'd1;
        end
      end
    end
  end

  // Control state resets; held values reset too since a record reads them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r <= '0;
      line_start_r  <= 1'b1;
      skip_hdr_r    <= 1'b0;
      num_acc_r     <= '0;
      num_neg_r     <= 1'b0;
      num_stop_r    <= 1'b0;
      cig_acc_r     <= '0;
      flags_r       <= '0;
      pos_r         <= '0;
      mapq_r        <= '0;
      mpos_r        <= '0;
      tlen_r        <= '0;
      char_cnt_r    <= '0;
      is_star_r     <= 1'b0;
      seq_r         <= 1'b0;
      qual_r        <= 1'b0;
    end else if (step_en) begin
      field_index_r <= field_index_nxt;
      line_start_r  <= line_start_nxt;
      skip_hdr_r    <= skip_hdr_nxt;
      num_acc_r     <= num_acc_nxt;
      num_neg_r     <= num_neg_nxt;
      num_stop_r    <= num_stop_nxt;
      cig_acc_r     <= cig_acc_nxt;
      flags_r       <= flags_nxt;
      pos_r         <= pos_nxt;
      mapq_r        <= mapq_nxt;
      mpos_r        <= mpos_nxt;
      tlen_r        <= tlen_nxt;
      char_cnt_r    <= char_cnt_nxt;
      is_star_r     <= is_star_nxt;
      seq_r         <= seq_nxt;
      qual_r        <= qual_nxt;
    end
  end

endmodule

[rtl/sfp_out_reg.sv]
// Result register of the parser: holds one result item until it is taken.
// Depends on sfp_pkg for the result type.
module sfp_out_reg
  import sfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load_valid,
  input  res_t load_res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r;
  res_t res_r;

  // Free when empty or when the held item leaves this cycle.
  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= load_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

[rtl/sam_record_field_parser_top.sv]
// Top level of the SAM record field parser: input register, parser core and
// result register. Depends on sfp_pkg, sfp_core and sfp_out_reg.
//
//   Port group | Dir | Item contents
//   in_*       | in  | one text byte (tdata[7:0])
//   out_*      | out | one cigar operation or end of record result
//
// An accepted byte is held in the input register while the core computes its
// update combinationally; the result register loads that update when the core
// steps, so a result is offered from the result register. One byte is accepted
// per cycle while the result register is not stalled.
// Reset is synchronous and active low; it clears the line state and empties
// both registers. A stalled output holds the result register, which stalls
// the core and then the input register; no item is lost.
module sam_record_field_parser_top
  import sfp_pkg::*;
#(
  parameter int MIN_FIELDS = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [3:0] cigar_type, [31:4] cigar_length,
                                   // [47:32] flag_bits, [78:48] position,
                                   // [86:79] map_quality, [117:87] mate_position,
                                   // [149:118] template_length, [150] has_sequence,
                                   // [151] has_quality, [152] has_optional,
                                   // [153] well_formed, [159:154] zero
  output logic         out_tuser   // [0] kind
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       can_load;
  logic       step_en;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // Input register advances whenever the core can take its byte.
  assign step_en   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  sfp_core #(
    .MIN_FIELDS(MIN_FIELDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sfp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (step_en && res_valid),
    .load_res   (res),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Pack the result fields, lowest field first.
  assign out_tuser = out_res.kind;
  assign out_tdata = {6'd0,
                      out_res.well_formed,
                      out_res.has_optional,
                      out_res.has_quality,
                      out_res.has_sequence,
                      out_res.template_length,
                      out_res.mate_position,
                      out_res.map_quality,
                      out_res.position,
                      out_res.flag_bits,
                      out_res.cigar_length,
                      out_res.cigar_type};

endmodule

[verif/testbench.sv]
// Self-checking testbench for sam_record_field_parser_top: streams SAM text bytes
// with random gaps and output stalls, and checks every cigar and record item.
// Depends on sfp_pkg and the parser RTL only.
module testbench;
  import sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_FIELDS = 11;
  localparam logic [27:0] CIGAR_LIMIT = 28'hFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic         out_tuser;

  sam_record_field_parser_top #(.MIN_FIELDS(MIN_FIELDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Text bytes waiting to be sent, and results the parser still owes us.
  logic [7:0] text_q[$];
  res_t       pending_results[$];
  int         errors = 0;
  bit         byte_taken = 1'b0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;

  // Line state of the predicted parser.
  logic [3:0]  fidx;
  bit          line_start;
  bit          in_header;
  logic [31:0] mag;
  bit          neg;
  bit          stopped;
  logic [27:0] cig;
  logic [15:0] h_flag;
  logic [30:0] h_pos;
  logic [7:0]  h_mapq;
  logic [30:0] h_mpos;
  logic [31:0] h_tlen;
  logic [1:0]  nchars;
  bit          star;
  bit          seq_p;
  bit          qual_p;

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturating decode of the current number for an unsigned result field.
  function automatic logic [31:0] clamp_unsigned(input logic [31:0] maxv);
    if (neg) return 32'd0;
    return (mag > maxv) ? maxv : mag;
  endfunction

  // Saturating decode of the current number as a signed 32-bit value.
  function automatic logic [31:0] clamp_signed();
    logic [31:0] m;
    m = mag;
    if (neg) begin
      if (m > MAG_CAP) m = MAG_CAP;
      return 32'd0 - m;
    end
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

  function automatic logic [3:0] cigar_code(input logic [7:0] b);
    case (b)
      "M":     return OP_M;
      "I":     return OP_I;
      "D":     return OP_D;
      "N":     return OP_N;
      "S":     return OP_S;
      "H":     return OP_H;
      "P":     return OP_P;
      "=":     return OP_EQ;
      "X":     return OP_X;
      default: return OP_UNK;
    endcase
  endfunction

  task automatic start_field();
    mag = '0;
    neg = 1'b0;
    stopped = 1'b0;
    cig = '0;
    nchars = '0;
    star = 1'b0;
  endtask

  task automatic clear_line();
    start_field();
    fidx = '0;
    h_flag = '0;
    h_pos = '0;
    h_mapq = '0;
    h_mpos = '0;
    h_tlen = '0;
    seq_p = 1'b0;
    qual_p = 1'b0;
  endtask

  // Latch the value of the field that just ended.
  task automatic end_field();
    bit present;
    present = !(nchars == 2'd1 && star);
    case (fidx)
      FLD_FLAG: h_flag = 16'(clamp_unsigned(FLAG_MAX));
      FLD_POS:  h_pos  = 31'(clamp_unsigned(POS_MAX));
      FLD_MAPQ: h_mapq = 8'(clamp_unsigned(MAPQ_MAX));
      FLD_MPOS: h_mpos = 31'(clamp_unsigned(POS_MAX));
      FLD_TLEN: h_tlen = clamp_signed();
      FLD_SEQ:  seq_p  = present;
      FLD_QUAL: qual_p = present;
      default: ;
    endcase
  endtask

  // Advance the predicted parser by one text byte; emit is set when a
  // result item is due.
  task automatic parse_sam_byte(input logic [7:0] b, output bit emit, output res_t r);
    logic [35:0] acc;
    bit          digit;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    emit = 1'b0;
    r = '0;
    if (b == CH_NL) begin
      if (in_header) begin
        in_header = 1'b0;
      end else begin
        end_field();
        r.kind = KIND_RECORD;
        r.flag_bits = h_flag;
        r.position = h_pos;
        r.map_quality = h_mapq;
        r.mate_position = h_mpos;
        r.template_length = h_tlen;
        r.has_sequence = seq_p;
        r.has_quality = qual_p;
        r.has_optional = (fidx >= FLD_OPT);
        r.well_formed = ({1'b0, fidx} + 5'd1 >= 5'(MIN_FIELDS));
        emit = 1'b1;
      end
      clear_line();
      line_start = 1'b1;
      return;
    end
    if (line_start && b == CH_AT) in_header = 1'b1;
    line_start = 1'b0;
    if (in_header) return;
    if (b == CH_TAB) begin
      end_field();
      start_field();
      if (fidx < FLD_MAX) fidx = fidx + 4'd1;
      return;
    end
    case (fidx)
      FLD_FLAG, FLD_POS, FLD_MAPQ, FLD_MPOS, FLD_TLEN: begin
        if (!stopped) begin
          if (nchars == 2'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
            neg = (b == CH_MINUS);
          end else if (digit) begin
            acc = 36'(mag) * 36'd10 + 36'(b - CH_ZERO);
            mag = (acc > 36'(MAG_CAP)) ? MAG_CAP : acc[31:0];
          end else begin
            stopped = 1'b1;
          end
        end
      end
      FLD_CIGAR: begin
        if (digit) begin
          acc = 36'(cig) * 36'd10 + 36'(b - CH_ZERO);
          cig = (acc > 36'(CIGAR_LIMIT)) ? CIGAR_LIMIT : acc[27:0];
        end else if (b != CH_STAR) begin
          r.kind = KIND_CIGAR;
          r.cigar_type = cigar_code(b);
          r.cigar_length = cig;
          cig = '0;
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    if (nchars == 2'd0) star = (b == CH_STAR);
    if (nchars < 2'd2) nchars = nchars + 2'd1;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report(name, got, want);
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample both handshakes; predict on accepted bytes and check results.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t nxt;
    bit   emit;
    byte_taken = rst_n && in_tvalid && in_tready;
    if (byte_taken) begin
      parse_sam_byte(in_tdata, emit, nxt);
      if (emit) pending_results.push_back(nxt);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.cigar_type = out_tdata[3:0];
      got.cigar_length = out_tdata[31:4];
      got.flag_bits = out_tdata[47:32];
      got.position = out_tdata[78:48];
      got.map_quality = out_tdata[86:79];
      got.mate_position = out_tdata[117:87];
      got.template_length = out_tdata[149:118];
      got.has_sequence = out_tdata[150];
      got.has_quality = out_tdata[151];
      got.has_optional = out_tdata[152];
      got.well_formed = out_tdata[153];
      if (pending_results.size() == 0) begin
        report("result item with none expected, kind", 32'(got.kind), 32'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("cigar_type", 32'(got.cigar_type), 32'(want.cigar_type));
        check_field("cigar_length", 32'(got.cigar_length), 32'(want.cigar_length));
        check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
        check_field("position", 32'(got.position), 32'(want.position));
        check_field("map_quality", 32'(got.map_quality), 32'(want.map_quality));
        check_field("mate_position", 32'(got.mate_position), 32'(want.mate_position));
        check_field("template_length", got.template_length, want.template_length);
        check_field("has_sequence", 32'(got.has_sequence), 32'(want.has_sequence));
        check_field("has_quality", 32'(got.has_quality), 32'(want.has_quality));
        check_field("has_optional", 32'(got.has_optional), 32'(want.has_optional));
        check_field("well_formed", 32'(got.well_formed), 32'(want.well_formed));
        check_field("tdata padding", 32'(out_tdata[159:154]), 32'd0);
      end
    end
    // Switch between stretches with and without idling now and then.
    if ($urandom_range(0, 299) == 0) calm = !calm;
  end

  // Byte driver: hold an item until taken, then present the next one after a gap.
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_tdata <= text_q.pop_front();
        in_tvalid <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_text(input int lo, input int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
  endtask

  // Numeric field: optional sign or leading blank, short or overlong digits,
  // sometimes followed by junk that stops the number.
  task automatic push_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) text_q.push_back(" ");
    else if (r < 30) text_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    r = $urandom_range(0, 99);
    if (r >= 5 && r < 80) push_digits($urandom_range(1, 5));
    else if (r >= 80) push_digits($urandom_range(9, 12));
    if ($urandom_range(0, 9) == 0) begin
      text_q.push_back($urandom_range(0, 1) ? CH_MINUS : "x");
      push_digits($urandom_range(1, 3));
    end
  endtask

  // CIGAR field: a star alone, or operations with lengths of all sizes.
  task automatic push_cigar();
    string ops;
    int    r;
    ops = "MIDNSHP=X";
    if ($urandom_range(0, 99) < 12) begin
      text_q.push_back(CH_STAR);
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r >= 10 && r < 85) push_digits($urandom_range(1, 4));
      else if (r >= 85) push_digits($urandom_range(8, 10));
      r = $urandom_range(0, 99);
      if (r < 5) text_q.push_back(CH_STAR);
      if (r < 85) text_q.push_back(ops[$urandom_range(0, 8)]);
      else push_text(1, 1);
    end
    if ($urandom_range(0, 99) < 15) push_digits($urandom_range(1, 3));
  endtask

  // SEQ or QUAL: a star, an empty field, near-stars, or bases.
  task automatic push_bases();
    string bases;
    int    r;
    bases = "ACGTN";
    r = $urandom_range(0, 99);
    if (r < 30) push_str("*");
    else if (r < 40) ;
    else if (r < 45) push_str("**");
    else if (r < 50) push_str("*A");
    else repeat ($urandom_range(1, 12)) text_q.push_back(bases[$urandom_range(0, 4)]);
  endtask

  initial begin
    int r;
    int nf;
    clear_line();
    line_start = 1'b1;
    in_header = 1'b0;

    // Directed lines: header, empty line, short line, saturating extremes,
    // every CIGAR operation with star and trailing digits, sign and junk
    // handling, empty SEQ, optional tags and a field count beyond sixteen.
    push_str("@HD\tVN:1.6\tx\n");
    push_str("\n");
    push_str("r1\t-4\tc\t 7\n");
    push_str("r2\t65536\tc\t2147483648\t256\t");
    push_str("268435456M1I2D3N4S5H6P7=8X*9Z10\t=\t+2147483647\t-2147483649\t*\t*\n");
    push_str("r3\t12-3\tc\t-\t+99\t0M\t*\t1\t2147483648\t\t**\tNM:i:0\n");
    push_str("r@4\t+\tc\t4294967296\t-1\t*\t=\t-5\t-2147483648\tACGT\t*A");
    push_str("\tX\tY\tZ\tW\tV\tU\tT\n");

    // Random lines: mostly well-formed records, plus headers, short lines,
    // very wide lines and raw byte noise.
    while (text_q.size() < 1380) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        text_q.push_back(CH_AT);
        push_text(0, 6);
        if ($urandom_range(0, 1)) begin
          text_q.push_back(CH_TAB);
          push_text(1, 6);
        end
      end else if (r < 12) begin
        repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        if (r < 20) nf = $urandom_range(1, 10);
        else if (r < 90) nf = $urandom_range(11, 13);
        else nf = $urandom_range(14, 20);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) text_q.push_back(CH_TAB);
          case (f)
            1, 3, 4, 7, 8: push_number();
            5:             push_cigar();
            9, 10:         push_bases();
            6:             if ($urandom_range(0, 1)) push_str("="); else push_text(1, 6);
            default:       push_text(1, 8);
          endcase
        end
      end
      text_q.push_back(CH_NL);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all bytes accepted, all results seen, then an idle wait before the verdict.
    while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
